// ----- sv/bal_pkg.sv -----
// Shared types and constants for the bump allocator with allocation registry.
package bal_pkg;

  localparam int REGISTRY_ENTRIES = 64;
  localparam int REGION_BYTES     = 1048576;
  localparam int ALIGN_BYTES      = 16;

  localparam int SLOT_W = $clog2(REGISTRY_ENTRIES);
  localparam int IDX_W  = SLOT_W + 1;
  localparam int CNT_W  = 7;
  localparam int OFF_W  = 20;
  localparam int SIZE_W = 21;
  localparam int POS_W  = 21;
  localparam int SUM_W  = 22;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALLOC_NULL = 2'd1,
    ST_DOUBLE     = 2'd2,
    ST_INVALID    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_UNUSED = 2'd0,
    MARK_LIVE   = 2'd1,
    MARK_FREE   = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  block_offset;
    logic              null_pointer;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] granted_offset;
    logic [CNT_W-1:0] live_entries;
    logic [CNT_W-1:0] free_entries;
    logic [POS_W-1:0] bump_position;
  } rsp_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    mark_t            mark;
  } entry_t;

endpackage

// ----- sv/bal_if.sv -----
// Request and response channel interfaces for the bump allocator.
interface bal_req_if;
  logic          valid;
  logic          ready;
  bal_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bal_rsp_if;
  logic          valid;
  logic          ready;
  bal_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/bump_allocator_with_registry_top.sv -----
// Bump allocator top level: request decode, registry scan and result register.
//
// One request is handled at a time and each gives exactly one result. A zero,
// oversize or non-fitting allocate and a null release skip the scan and go
// straight to the result. Any other request scans the registry in slot order,
// one entry read per cycle from the registry memory, and stops at the first
// deciding slot or after the last of the 64 slots. The read rate of the single
// registry memory sets the scan speed. The result register frees the request
// side, so the next request may start while a result waits to be taken.
// Reported offsets are relative to the region start; slot marks come out of
// reset as unused with no clearing pass.
module bump_allocator_with_registry_top (
  input logic      clk,
  input logic      rst,
  bal_req_if.sink   req,
  bal_rsp_if.source rsp
);

  localparam int N = bal_pkg::REGISTRY_ENTRIES;

  // Registry memory and per-slot valid bits
  bal_pkg::entry_t mem [N];
  logic [N-1:0]    entry_vld;
  bal_pkg::entry_t rd_entry;
  logic            rd_vld;

  // Control and request registers
  bal_pkg::state_t  state, state_next;
  bal_pkg::cmd_t    cmd_q;
  logic [bal_pkg::SIZE_W-1:0] size_q;
  logic [bal_pkg::OFF_W-1:0]  off_q;
  logic [bal_pkg::POS_W-1:0]  aligned_q;
  bal_pkg::status_t status_q;
  logic             upd_q;
  logic             reuse_q;
  logic [bal_pkg::SLOT_W-1:0] slot_q;
  logic [bal_pkg::IDX_W-1:0]  issue_idx;
  logic             pipe_vld;
  logic [bal_pkg::SLOT_W-1:0] pipe_idx;

  logic [bal_pkg::CNT_W-1:0]  live_total, free_total;
  logic [bal_pkg::POS_W-1:0]  bump_offset;

  logic             out_valid;
  bal_pkg::rsp_t    out_data;

  // Combinational signals
  logic [bal_pkg::SUM_W-1:0]  aligned_in;
  logic             early;
  bal_pkg::status_t early_status;
  bal_pkg::mark_t   chk_mark;
  logic             chk_hit, chk_double, chk_last, scan_done;
  logic             out_free;
  logic             accept;
  logic             mem_we;
  bal_pkg::entry_t  wr_entry;
  logic [bal_pkg::CNT_W-1:0]  live_next, free_next;
  logic [bal_pkg::POS_W-1:0]  bump_next;
  logic [bal_pkg::OFF_W-1:0]  granted;

  // Precheck an incoming request against size, fit and null pointer
  always_comb begin
    aligned_in = (bal_pkg::SUM_W'(bump_offset) + bal_pkg::SUM_W'(bal_pkg::ALIGN_BYTES - 1))
                 & ~bal_pkg::SUM_W'(bal_pkg::ALIGN_BYTES - 1);
    early        = 1'b0;
    early_status = bal_pkg::ST_OK;
    if (req.data.cmd == bal_pkg::CMD_ALLOC) begin
      if (req.data.request_size == '0
          || bal_pkg::SUM_W'(req.data.request_size) > bal_pkg::SUM_W'(bal_pkg::REGION_BYTES)
          || aligned_in + bal_pkg::SUM_W'(req.data.request_size)
             > bal_pkg::SUM_W'(bal_pkg::REGION_BYTES)) begin
        early        = 1'b1;
        early_status = bal_pkg::ST_ALLOC_NULL;
      end
    end else if (req.data.null_pointer) begin
      early        = 1'b1;
      early_status = bal_pkg::ST_OK;
    end
  end

  // Check the entry read in the previous cycle
  always_comb begin
    chk_mark   = rd_vld ? rd_entry.mark : bal_pkg::MARK_UNUSED;
    chk_hit    = 1'b0;
    chk_double = 1'b0;
    if (cmd_q == bal_pkg::CMD_ALLOC) begin
      chk_hit = (chk_mark != bal_pkg::MARK_LIVE);
    end else if (rd_entry.offset == off_q) begin
      chk_hit    = (chk_mark == bal_pkg::MARK_LIVE);
      chk_double = (chk_mark == bal_pkg::MARK_FREE);
    end
    chk_last  = (pipe_idx == bal_pkg::SLOT_W'(N - 1));
    scan_done = pipe_vld && (chk_hit || chk_double || chk_last);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bal_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = early ? bal_pkg::S_FINISH : bal_pkg::S_SCAN;
        end
      end
      bal_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = bal_pkg::S_FINISH;
        end
      end
      bal_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = bal_pkg::S_IDLE;
        end
      end
      default: state_next = bal_pkg::S_IDLE;
    endcase
  end

  // State-driven outputs and update values
  always_comb begin
    out_free  = !out_valid || rsp.ready;
    req.ready = (state == bal_pkg::S_IDLE);
    accept    = req.valid && (state == bal_pkg::S_IDLE);
    mem_we    = (state == bal_pkg::S_FINISH) && out_free && upd_q;

    live_next = live_total;
    free_next = free_total;
    bump_next = bump_offset;
    granted   = '0;
    if (cmd_q == bal_pkg::CMD_ALLOC) begin
      wr_entry.offset = aligned_q[bal_pkg::OFF_W-1:0];
      wr_entry.mark   = bal_pkg::MARK_LIVE;
      if (upd_q) begin
        live_next = live_total + 1'b1;
        free_next = reuse_q ? free_total - 1'b1 : free_total;
        bump_next = bal_pkg::POS_W'(aligned_q + size_q);
        granted   = aligned_q[bal_pkg::OFF_W-1:0];
      end
    end else begin
      wr_entry.offset = off_q;
      wr_entry.mark   = bal_pkg::MARK_FREE;
      if (upd_q) begin
        live_next = live_total - 1'b1;
        free_next = free_total + 1'b1;
      end
    end
  end

  // Registry memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_q] <= wr_entry;
    end
    rd_entry <= mem[issue_idx[bal_pkg::SLOT_W-1:0]];
    rd_vld   <= entry_vld[issue_idx[bal_pkg::SLOT_W-1:0]];
  end

  // Control, request and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bal_pkg::S_IDLE;
      entry_vld   <= '0;
      live_total  <= '0;
      free_total  <= '0;
      bump_offset <= '0;
      out_valid   <= 1'b0;
      pipe_vld    <= 1'b0;
      issue_idx   <= '0;
      upd_q       <= 1'b0;
    end else begin
      state <= state_next;

      // Latch the request and start the scan
      if (accept) begin
        cmd_q     <= req.data.cmd;
        size_q    <= req.data.request_size;
        off_q     <= req.data.block_offset;
        aligned_q <= aligned_in[bal_pkg::POS_W-1:0];
        status_q  <= early_status;
        upd_q     <= 1'b0;
        reuse_q   <= 1'b0;
        issue_idx <= '0;
        pipe_vld  <= 1'b0;
      end

      // Advance the scan, one read issued per cycle
      if (state == bal_pkg::S_SCAN) begin
        if (scan_done) begin
          pipe_vld <= 1'b0;
          slot_q   <= pipe_idx;
          reuse_q  <= (chk_mark == bal_pkg::MARK_FREE);
          if (chk_hit) begin
            status_q <= bal_pkg::ST_OK;
            upd_q    <= 1'b1;
          end else if (chk_double) begin
            status_q <= bal_pkg::ST_DOUBLE;
          end else if (cmd_q == bal_pkg::CMD_ALLOC) begin
            status_q <= bal_pkg::ST_ALLOC_NULL;
          end else begin
            status_q <= bal_pkg::ST_INVALID;
          end
        end else if (issue_idx < bal_pkg::IDX_W'(N)) begin
          pipe_vld  <= 1'b1;
          pipe_idx  <= issue_idx[bal_pkg::SLOT_W-1:0];
          issue_idx <= issue_idx + 1'b1;
        end else begin
          pipe_vld <= 1'b0;
        end
      end

      // Commit the update and load the result register
      if (state == bal_pkg::S_FINISH && out_free) begin
        if (upd_q) begin
          entry_vld[slot_q] <= 1'b1;
        end
        live_total               <= live_next;
        free_total               <= free_next;
        bump_offset              <= bump_next;
        out_valid                <= 1'b1;
        out_data.status          <= status_q;
        out_data.granted_offset  <= granted;
        out_data.live_entries    <= live_next;
        out_data.free_entries    <= free_next;
        out_data.bump_position   <= bump_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

// ----- bench/bump_allocator_with_registry_top_tb.sv -----
// Self-checking testbench for the bump allocator with allocation registry.
module bump_allocator_with_registry_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bal_pkg::*;

  localparam int RANDOM_ITEMS = 930;
  localparam int LATE_START   = 780;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD    = 600;
  localparam int TAIL_CYCLES  = 100;
  localparam int STALL_LIMIT  = 4000;

  typedef enum int {
    PH_FILL,
    PH_CHURN,
    PH_DRAIN,
    PH_NOISE
  } phase_e;

  typedef struct {
    req_t item;
    rsp_t outcome;
  } request_rec_t;

  logic clk;
  logic rst;

  bal_req_if req_ch ();
  bal_rsp_if rsp_ch ();

  bump_allocator_with_registry_top DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the allocator registry and counters
  logic [OFF_W-1:0]  slot_off  [REGISTRY_ENTRIES];
  logic [SIZE_W-1:0] slot_size [REGISTRY_ENTRIES];
  mark_t             slot_mark [REGISTRY_ENTRIES];
  logic [CNT_W-1:0]  live_cnt;
  logic [CNT_W-1:0]  free_cnt;
  logic [POS_W-1:0]  bump_pos;

  request_rec_t pending_reqs[$];
  rsp_t         awaited_rsp[$];
  int           mismatch_cnt;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned align_up(int unsigned pos);
    return ((pos + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  // Apply one request to the shadow registry and return the response it gives
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    int unsigned aligned_pos;
    int unsigned size;
    int          slot;
    bit          hit;
    o = '0;
    o.status = ST_OK;
    size = r.request_size;
    if (r.cmd == CMD_ALLOC) begin
      aligned_pos = align_up(bump_pos);
      slot = REGISTRY_ENTRIES;
      for (int i = REGISTRY_ENTRIES - 1; i >= 0; i--) begin
        if (slot_mark[i] != MARK_LIVE) slot = i;
      end
      if (size == 0 || size > REGION_BYTES || aligned_pos + size > REGION_BYTES ||
          slot == REGISTRY_ENTRIES) begin
        o.status = ST_ALLOC_NULL;
      end else begin
        if (slot_mark[slot] == MARK_FREE) free_cnt = free_cnt - 1'b1;
        slot_off[slot]  = aligned_pos[OFF_W-1:0];
        slot_size[slot] = size[SIZE_W-1:0];
        slot_mark[slot] = MARK_LIVE;
        live_cnt = live_cnt + 1'b1;
        bump_pos = aligned_pos + size;
        o.granted_offset = aligned_pos[OFF_W-1:0];
      end
    end else if (!r.null_pointer) begin
      // first slot holding the offset decides; unused slots are skipped
      o.status = ST_INVALID;
      hit = 1'b0;
      for (int i = 0; i < REGISTRY_ENTRIES && !hit; i++) begin
        if (slot_off[i] == r.block_offset) begin
          if (slot_mark[i] == MARK_FREE) begin
            o.status = ST_DOUBLE;
            hit = 1'b1;
          end else if (slot_mark[i] == MARK_LIVE) begin
            slot_mark[i] = MARK_FREE;
            live_cnt = live_cnt - 1'b1;
            free_cnt = free_cnt + 1'b1;
            o.status = ST_OK;
            hit = 1'b1;
          end
        end
      end
    end
    o.live_entries  = live_cnt;
    o.free_entries  = free_cnt;
    o.bump_position = bump_pos;
    return o;
  endfunction

  task automatic push_request(cmd_t c, int unsigned size, int unsigned off, bit nul);
    request_rec_t rec;
    rec.item.cmd          = c;
    rec.item.request_size = size[SIZE_W-1:0];
    rec.item.block_offset = off[OFF_W-1:0];
    rec.item.null_pointer = nul;
    rec.outcome = apply_request(rec.item);
    pending_reqs.push_back(rec);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t %s mismatch: expected %0d actual %0d", $realtime, name, want, got);
    end
  endtask

  // Stimulus: directed corner requests, then phased random traffic
  initial begin
    phase_e      phase;
    int          phase_left;
    int          alloc_pct;
    int unsigned room;
    int unsigned size;
    int          pick;
    int          known[$];
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    mismatch_cnt = 0;
    for (int i = 0; i < REGISTRY_ENTRIES; i++) begin
      slot_off[i]  = '0;
      slot_size[i] = '0;
      slot_mark[i] = MARK_UNUSED;
    end
    live_cnt = '0;
    free_cnt = '0;
    bump_pos = '0;

    // zero, oversize and releases into an empty registry
    push_request(CMD_ALLOC, 0, 0, 1'b0);
    push_request(CMD_ALLOC, 21'h1FFFFF, 20'hFFFFF, 1'b0);
    push_request(CMD_ALLOC, REGION_BYTES + 1, 0, 1'b0);
    push_request(CMD_RELEASE, 0, 0, 1'b0);
    push_request(CMD_RELEASE, 0, 0, 1'b1);
    // first block, then one that no longer fits the region
    push_request(CMD_ALLOC, 1, 0, 1'b0);
    push_request(CMD_ALLOC, REGION_BYTES, 0, 1'b0);
    push_request(CMD_ALLOC, 17, 0, 1'b0);
    // free, double free, unknown offset, null release
    push_request(CMD_RELEASE, 0, 16, 1'b0);
    push_request(CMD_RELEASE, 0, 16, 1'b0);
    push_request(CMD_RELEASE, 21'h1FFFFF, 20'hFFFFF, 1'b0);
    push_request(CMD_RELEASE, 0, 0, 1'b1);
    // reuse a freed slot; allocate ignores offset and null flag
    push_request(CMD_ALLOC, 100, 20'hFFFFF, 1'b1);
    push_request(CMD_RELEASE, 0, 0, 1'b0);
    push_request(CMD_RELEASE, 0, 48, 1'b0);
    push_request(CMD_ALLOC, 2, 0, 1'b0);
    push_request(CMD_RELEASE, 0, 20'hFFFFF, 1'b1);
    push_request(CMD_ALLOC, 16, 0, 1'b0);
    push_request(CMD_RELEASE, 0, 16, 1'b0);
    push_request(CMD_RELEASE, 0, 48, 1'b0);

    // open with a long fill so the registry runs full
    phase = PH_FILL;
    phase_left = 90;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        pick = $urandom_range(0, 9);
        phase = (pick < 3) ? PH_FILL : (pick < 6) ? PH_CHURN :
                (pick < 9) ? PH_DRAIN : PH_NOISE;
        phase_left = $urandom_range(30, 90);
      end
      phase_left--;
      alloc_pct = (phase == PH_FILL) ? 90 : (phase == PH_CHURN) ? 55 : 25;
      if (phase == PH_NOISE) begin
        push_request(cmd_t'($urandom_range(0, 1)), $urandom, $urandom,
                     $urandom_range(0, 1));
      end else if ($urandom_range(0, 99) < alloc_pct) begin
        room = REGION_BYTES - align_up(bump_pos);
        pick = $urandom_range(0, 99);
        if (n >= LATE_START && pick < 30) size = $urandom_range(20000, 150000);
        else if (pick < 70) size = $urandom_range(1, 64);
        else if (pick < 85) size = $urandom_range(65, 4096);
        else if (pick < 88) size = 0;
        else if (pick < 91) size = $urandom_range(REGION_BYTES + 1, 21'h1FFFFF);
        else if (pick < 94) size = room;
        else if (pick < 96) size = room + 1;
        else size = $urandom_range(4097, 65536);
        push_request(CMD_ALLOC, size, $urandom, $urandom_range(0, 7) == 0);
      end else begin
        known.delete();
        for (int i = 0; i < REGISTRY_ENTRIES; i++) begin
          if (slot_mark[i] != MARK_UNUSED) known.push_back(i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 75 && known.size() > 0) begin
          pick = known[$urandom_range(0, known.size() - 1)];
          push_request(CMD_RELEASE, $urandom, slot_off[pick], 1'b0);
        end else if (pick < 85) begin
          push_request(CMD_RELEASE, $urandom, $urandom, 1'b1);
        end else if (pick < 93) begin
          push_request(CMD_RELEASE, $urandom, $urandom_range(0, 65535) << 4, 1'b0);
        end else begin
          push_request(CMD_RELEASE, $urandom, $urandom, 1'b0);
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // drain, then give the block time to show any stray result
    wait (pending_reqs.size() == 0 && !req_ch.valid && awaited_rsp.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && awaited_rsp.size() == 0) begin
      $display("[bump_allocator_with_registry_top] OK");
    end else begin
      $display("[bump_allocator_with_registry_top] ERROR");
    end
    $finish;
  end

  // Request driver: hold each item until taken, then wait a drawn gap
  int     offer_gap;
  bit     tx_burst;
  rsp_t   offered_rsp;

  always @(posedge clk) begin
    request_rec_t rec;
    logic         nxt_valid;
    req_t         nxt_data;
    nxt_valid = req_ch.valid;
    nxt_data  = req_ch.data;
    if (rst) begin
      nxt_valid = 1'b0;
      offer_gap = 0;
      tx_burst  = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) awaited_rsp.push_back(offered_rsp);
      if (!req_ch.valid || req_ch.ready) begin
        nxt_valid = 1'b0;
        if (offer_gap > 0) begin
          offer_gap--;
        end else if (pending_reqs.size() > 0) begin
          rec = pending_reqs.pop_front();
          nxt_valid   = 1'b1;
          nxt_data    = rec.item;
          offered_rsp = rec.outcome;
          if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
          offer_gap = tx_burst ? 0 : $urandom_range(0, 12);
        end
      end
    end
    req_ch.valid <= nxt_valid;
    req_ch.data  <= nxt_data;
  end

  // Response monitor: check each result and stall the output at random
  int hold_left;
  int rsp_seen;
  bit rx_burst;

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      hold_left = 0;
      rsp_seen  = 0;
      rx_burst  = 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (awaited_rsp.size() == 0) begin
          mismatch_cnt++;
          $display("%0t unexpected result: expected none actual status %0d offset %0d",
                   $realtime, rsp_ch.data.status, rsp_ch.data.granted_offset);
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("status", want.status, rsp_ch.data.status);
          compare_field("granted_offset", want.granted_offset, rsp_ch.data.granted_offset);
          compare_field("live_entries", want.live_entries, rsp_ch.data.live_entries);
          compare_field("free_entries", want.free_entries, rsp_ch.data.free_entries);
          compare_field("bump_position", want.bump_position, rsp_ch.data.bump_position);
        end
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        hold_left = rx_burst ? 0 : $urandom_range(0, 12);
        // one long hold-off so the block backs up into its input
        if (rsp_seen == LONG_HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[bump_allocator_with_registry_top] ERROR");
        $finish;
      end
    end
  end

endmodule
